// ----- rtl/mcpg_pkg.sv -----
package mcpg_pkg;

  localparam int COORD_BITS_DEF  = 16;
  localparam int RADIUS_BITS_DEF = 12;

  localparam logic REQ_START   = 1'b0;
  localparam logic REQ_ADVANCE = 1'b1;

  localparam logic KIND_CIRCLE = 1'b0;
  localparam logic KIND_RRECT  = 1'b1;

  localparam logic [2:0] MIRROR_FIRST = 3'd0;
  localparam logic [2:0] MIRROR_LAST  = 3'd7;

  typedef struct packed {
    logic       busy;
    logic       last;
    logic [2:0] index;
  } step_ctl_t;

endpackage

// ----- rtl/mcpg_in_if.sv -----
interface mcpg_in_if #(
  parameter int COORD_BITS  = mcpg_pkg::COORD_BITS_DEF,
  parameter int RADIUS_BITS = mcpg_pkg::RADIUS_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic                         req_type;
  logic                         shape_kind;
  logic signed [COORD_BITS-1:0] first_x;
  logic signed [COORD_BITS-1:0] first_y;
  logic signed [COORD_BITS-1:0] second_x;
  logic signed [COORD_BITS-1:0] second_y;
  logic [RADIUS_BITS-1:0]       radius_in;

  modport source (
    output valid, req_type, shape_kind, first_x, first_y, second_x, second_y, radius_in,
    input  ready
  );
  modport sink (
    input  valid, req_type, shape_kind, first_x, first_y, second_x, second_y, radius_in,
    output ready
  );
endinterface

// ----- rtl/mcpg_out_if.sv -----
interface mcpg_out_if #(
  parameter int COORD_BITS = mcpg_pkg::COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic                         point_valid;
  logic                         last_point;

  modport source (
    output valid, point_x, point_y, point_valid, last_point,
    input  ready
  );
  modport sink (
    input  valid, point_x, point_y, point_valid, last_point,
    output ready
  );
endinterface

// ----- rtl/mcpg_centre.sv -----
module mcpg_centre #(
  parameter int COORD_BITS  = mcpg_pkg::COORD_BITS_DEF,
  parameter int RADIUS_BITS = mcpg_pkg::RADIUS_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   load,
  input  logic                   shape_kind,
  input  logic [COORD_BITS-1:0]  first_x,
  input  logic [COORD_BITS-1:0]  first_y,
  input  logic [COORD_BITS-1:0]  second_x,
  input  logic [COORD_BITS-1:0]  second_y,
  input  logic [RADIUS_BITS-1:0] radius,
  output logic [COORD_BITS-1:0]  right,
  output logic [COORD_BITS-1:0]  bottom,
  output logic [COORD_BITS-1:0]  left,
  output logic [COORD_BITS-1:0]  top
);
  import mcpg_pkg::*;

  logic [COORD_BITS-1:0] rad_c;
  logic [COORD_BITS-1:0] right_r, bottom_r, left_r, top_r;
  logic [COORD_BITS-1:0] right_nxt, bottom_nxt, left_nxt, top_nxt;

  assign rad_c = COORD_BITS'(radius);

  always_comb begin
    if (shape_kind == KIND_RRECT) begin
      right_nxt  = second_x - rad_c;
      bottom_nxt = second_y - rad_c;
      left_nxt   = first_x + rad_c;
      top_nxt    = first_y + rad_c;
    end else begin
      right_nxt  = first_x;
      bottom_nxt = first_y;
      left_nxt   = first_x;
      top_nxt    = first_y;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      right_r  <= right_nxt;
      bottom_r <= bottom_nxt;
      left_r   <= left_nxt;
      top_r    <= top_nxt;
    end
  end

  assign right  = right_r;
  assign bottom = bottom_r;
  assign left   = left_r;
  assign top    = top_r;

endmodule

// ----- rtl/mcpg_stepper.sv -----
module mcpg_stepper #(
  parameter int RADIUS_BITS = mcpg_pkg::RADIUS_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic                   advance,
  input  logic [RADIUS_BITS-1:0] radius,
  output logic [RADIUS_BITS:0]   major,
  output logic [RADIUS_BITS:0]   minor,
  output mcpg_pkg::step_ctl_t    ctl
);
  import mcpg_pkg::*;

  localparam int OFF_BITS = RADIUS_BITS + 1;
  localparam int DEC_BITS = RADIUS_BITS + 4;

  logic                       busy_r, busy_nxt;
  logic [2:0]                 idx_r, idx_nxt;
  logic [OFF_BITS-1:0]        major_r, major_nxt;
  logic [OFF_BITS-1:0]        minor_r, minor_nxt;
  logic signed [DEC_BITS-1:0] dec_r, dec_nxt;

  logic                       dec_pos;
  logic                       done;
  logic                       wrap_iter;
  logic [OFF_BITS-1:0]        major_step;
  logic signed [DEC_BITS-1:0] minor_s, major_step_s, dec_step;
  logic [OFF_BITS:0]          major_w, minor_w;

  assign dec_pos      = !dec_r[DEC_BITS-1] && (dec_r != '0);
  assign major_step   = dec_pos ? (major_r - OFF_BITS'(1)) : major_r;
  assign minor_s      = signed'({3'b000, minor_r});
  assign major_step_s = signed'({3'b000, major_step});
  assign major_w      = {1'b0, major_r};
  assign minor_w      = {1'b0, minor_r};
  assign done         = dec_pos ? (major_w < minor_w + (OFF_BITS + 1)'(2))
                                : (major_w < minor_w + (OFF_BITS + 1)'(1));
  assign wrap_iter    = advance && busy_r && (idx_r == MIRROR_LAST);

  always_comb begin
    if (dec_pos) begin
      dec_step = dec_r + (minor_s <<< 1) - (major_step_s <<< 1) + DEC_BITS'(1);
    end else begin
      dec_step = dec_r + (minor_s <<< 1) + DEC_BITS'(1);
    end
  end

  always_comb begin
    busy_nxt  = busy_r;
    idx_nxt   = idx_r;
    major_nxt = major_r;
    minor_nxt = minor_r;
    dec_nxt   = dec_r;
    if (start) begin
      busy_nxt  = 1'b1;
      idx_nxt   = MIRROR_FIRST;
      major_nxt = OFF_BITS'(radius);
      minor_nxt = '0;
      dec_nxt   = DEC_BITS'(1) - signed'({4'b0000, radius});
    end else if (wrap_iter) begin
      idx_nxt   = MIRROR_FIRST;
      busy_nxt  = !done;
      major_nxt = major_step;
      minor_nxt = minor_r + OFF_BITS'(1);
      dec_nxt   = dec_step;
    end else if (advance && busy_r) begin
      idx_nxt = idx_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= MIRROR_FIRST;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    major_r <= major_nxt;
    minor_r <= minor_nxt;
    dec_r   <= dec_nxt;
  end

  assign major     = major_r;
  assign minor     = minor_r;
  assign ctl.busy  = busy_r;
  assign ctl.index = idx_r;
  assign ctl.last  = busy_r && (idx_r == MIRROR_LAST) && done;

endmodule

// ----- rtl/mcpg_mirror.sv -----
module mcpg_mirror #(
  parameter int COORD_BITS  = mcpg_pkg::COORD_BITS_DEF,
  parameter int RADIUS_BITS = mcpg_pkg::RADIUS_BITS_DEF
) (
  input  logic [COORD_BITS-1:0] right,
  input  logic [COORD_BITS-1:0] bottom,
  input  logic [COORD_BITS-1:0] left,
  input  logic [COORD_BITS-1:0] top,
  input  logic [RADIUS_BITS:0]  major,
  input  logic [RADIUS_BITS:0]  minor,
  input  mcpg_pkg::step_ctl_t   ctl,
  output logic [COORD_BITS-1:0] px,
  output logic [COORD_BITS-1:0] py
);
  import mcpg_pkg::*;

  logic [COORD_BITS-1:0] a_c, b_c;

  assign a_c = ctl.index[2] ? COORD_BITS'(minor) : COORD_BITS'(major);
  assign b_c = ctl.index[2] ? COORD_BITS'(major) : COORD_BITS'(minor);

  assign px = ctl.index[1] ? (left - a_c) : (right + a_c);
  assign py = ctl.index[0] ? (top - b_c) : (bottom + b_c);

endmodule

// ----- rtl/mcpg_out_stage.sv -----
module mcpg_out_stage #(
  parameter int COORD_BITS = mcpg_pkg::COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  load,
  input  logic [COORD_BITS-1:0] px,
  input  logic [COORD_BITS-1:0] py,
  input  mcpg_pkg::step_ctl_t   ctl,
  output logic                  can_load,
  mcpg_out_if.source            out_ch
);
  import mcpg_pkg::*;

  logic                  valid_r, valid_nxt;
  logic [COORD_BITS-1:0] px_r, py_r;
  logic                  pvalid_r, last_r;

  assign can_load  = !valid_r || out_ch.ready;
  assign valid_nxt = load || (valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // idle advance gives an empty point
  always_ff @(posedge clk) begin
    if (load) begin
      px_r     <= ctl.busy ? px : '0;
      py_r     <= ctl.busy ? py : '0;
      pvalid_r <= ctl.busy;
      last_r   <= ctl.last;
    end
  end

  assign out_ch.valid       = valid_r;
  assign out_ch.point_x     = signed'(px_r);
  assign out_ch.point_y     = signed'(py_r);
  assign out_ch.point_valid = pvalid_r;
  assign out_ch.last_point  = last_r;

endmodule

// ----- rtl/midpoint_circle_point_generator_unit.sv -----
// An advance item's point appears on the result channel in the cycle after acceptance.
// Throughput: one item per cycle unless the result channel stalls; a start item loads
// the shape and gives no result. The rate is set by the octant step and the output register,
// which accepts a new item when it is empty or its held point is taken in the same cycle.
// Reset (synchronous, rst_n low) leaves the unit idle with no result pending.
module midpoint_circle_point_generator_unit #(
  parameter int COORD_BITS  = mcpg_pkg::COORD_BITS_DEF,
  parameter int RADIUS_BITS = mcpg_pkg::RADIUS_BITS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  mcpg_in_if.sink    in_ch,
  mcpg_out_if.source out_ch
);
  import mcpg_pkg::*;

  logic                  in_fire, start, advance, can_load;
  logic [COORD_BITS-1:0] right, bottom, left, top, px, py;
  logic [RADIUS_BITS:0]  major, minor;
  step_ctl_t             ctl;

  assign in_ch.ready = can_load;
  assign in_fire     = in_ch.valid && can_load;
  assign start       = in_fire && (in_ch.req_type == REQ_START);
  assign advance     = in_fire && (in_ch.req_type == REQ_ADVANCE);

  mcpg_centre #(
    .COORD_BITS (COORD_BITS),
    .RADIUS_BITS(RADIUS_BITS)
  ) u_centre (
    .clk       (clk),
    .load      (start),
    .shape_kind(in_ch.shape_kind),
    .first_x   (in_ch.first_x),
    .first_y   (in_ch.first_y),
    .second_x  (in_ch.second_x),
    .second_y  (in_ch.second_y),
    .radius    (in_ch.radius_in),
    .right     (right),
    .bottom    (bottom),
    .left      (left),
    .top       (top)
  );

  mcpg_stepper #(
    .RADIUS_BITS(RADIUS_BITS)
  ) u_stepper (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .advance(advance),
    .radius (in_ch.radius_in),
    .major  (major),
    .minor  (minor),
    .ctl    (ctl)
  );

  mcpg_mirror #(
    .COORD_BITS (COORD_BITS),
    .RADIUS_BITS(RADIUS_BITS)
  ) u_mirror (
    .right (right),
    .bottom(bottom),
    .left  (left),
    .top   (top),
    .major (major),
    .minor (minor),
    .ctl   (ctl),
    .px    (px),
    .py    (py)
  );

  mcpg_out_stage #(
    .COORD_BITS(COORD_BITS)
  ) u_out_stage (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (advance),
    .px      (px),
    .py      (py),
    .ctl     (ctl),
    .can_load(can_load),
    .out_ch  (out_ch)
  );

endmodule

// ----- bench/midpoint_circle_point_generator_unit_tb.sv -----
module midpoint_circle_point_generator_unit_tb;
  import mcpg_pkg::*;

  localparam int CB = COORD_BITS_DEF;
  localparam int RB = RADIUS_BITS_DEF;
  localparam int RMAX = (1 << RB) - 1;
  localparam int RANDOM_ITEMS = 528;
  localparam int STALL_LIMIT = 2000;

  typedef struct packed {
    logic                 req;
    logic                 kind;
    logic signed [CB-1:0] fx;
    logic signed [CB-1:0] fy;
    logic signed [CB-1:0] sx;
    logic signed [CB-1:0] sy;
    logic [RB-1:0]        radius;
  } shape_req_t;

  typedef struct packed {
    logic [CB-1:0] px;
    logic [CB-1:0] py;
    logic          pvalid;
    logic          last;
  } point_t;

  class point_scoreboard;
    int            major;
    int            minor;
    int            decision;
    logic [2:0]    mirror;
    logic          drawing;
    logic          kind;
    logic [CB-1:0] corner[4];
    logic [RB-1:0] radius;
    point_t        expected_points[$];
    int            errors;

    function new();
      major = 0;
      minor = 0;
      decision = 0;
      mirror = MIRROR_FIRST;
      drawing = 1'b0;
      kind = KIND_CIRCLE;
      foreach (corner[i]) corner[i] = '0;
      radius = '0;
      errors = 0;
    endfunction

    function bit is_drawing();
      return drawing;
    endfunction

    function int pending();
      return expected_points.size();
    endfunction

    function void note_request(shape_req_t it);
      point_t        p;
      logic [CB-1:0] rad_c;
      logic [CB-1:0] right;
      logic [CB-1:0] bottom;
      logic [CB-1:0] left;
      logic [CB-1:0] top;
      int            a;
      int            b;
      if (it.req == REQ_START) begin
        kind = it.kind;
        corner[0] = it.fx;
        corner[1] = it.fy;
        corner[2] = it.sx;
        corner[3] = it.sy;
        radius = it.radius;
        major = int'(it.radius);
        minor = 0;
        decision = 1 - int'(it.radius);
        mirror = MIRROR_FIRST;
        drawing = 1'b1;
        return;
      end
      p = '0;
      if (!drawing) begin
        expected_points.push_back(p);
        return;
      end
      rad_c = '0;
      rad_c[RB-1:0] = radius;
      if (kind == KIND_RRECT) begin
        right = corner[2] - rad_c;
        bottom = corner[3] - rad_c;
        left = corner[0] + rad_c;
        top = corner[1] + rad_c;
      end else begin
        right = corner[0];
        left = corner[0];
        bottom = corner[1];
        top = corner[1];
      end
      a = (mirror < 3'd4) ? major : minor;
      b = (mirror < 3'd4) ? minor : major;
      p.px = mirror[1] ? left - a[CB-1:0] : right + a[CB-1:0];
      p.py = mirror[0] ? top - b[CB-1:0] : bottom + b[CB-1:0];
      p.pvalid = 1'b1;
      if (mirror == MIRROR_LAST) begin
        if (decision <= 0) begin
          decision += 2 * minor + 1;
        end else begin
          major -= 1;
          decision += 2 * minor - 2 * major + 1;
        end
        minor += 1;
        mirror = MIRROR_FIRST;
        if (major < minor) begin
          p.last = 1'b1;
          drawing = 1'b0;
        end
      end else begin
        mirror = mirror + 3'd1;
      end
      expected_points.push_back(p);
    endfunction

    task report(string what);
      $display("MISMATCH: %s", what);
      errors++;
    endtask

    task check_point(point_t got);
      point_t want;
      if (expected_points.size() == 0) begin
        report($sformatf("unexpected point x=%h y=%h valid=%b last=%b",
                         got.px, got.py, got.pvalid, got.last));
        return;
      end
      want = expected_points.pop_front();
      if (got.px !== want.px)
        report($sformatf("point_x got %h expected %h", got.px, want.px));
      if (got.py !== want.py)
        report($sformatf("point_y got %h expected %h", got.py, want.py));
      if (got.pvalid !== want.pvalid)
        report($sformatf("point_valid got %b expected %b", got.pvalid, want.pvalid));
      if (got.last !== want.last)
        report($sformatf("last_point got %b expected %b", got.last, want.last));
    endtask
  endclass

  logic clk;
  logic rst_n;
  int   sender_idle_pct;
  int   recv_stall_pct;
  int   items_sent;
  int   stall_cycles;
  point_scoreboard sb;

  mcpg_in_if #(.COORD_BITS(CB), .RADIUS_BITS(RB)) in_ch();
  mcpg_out_if #(.COORD_BITS(CB)) out_ch();

  midpoint_circle_point_generator_unit #(
    .COORD_BITS(CB),
    .RADIUS_BITS(RB)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic shape_req_t shape_start(logic k, logic [CB-1:0] fx, logic [CB-1:0] fy,
                                             logic [CB-1:0] sx, logic [CB-1:0] sy,
                                             logic [RB-1:0] r);
    shape_req_t it;
    it.req = REQ_START;
    it.kind = k;
    it.fx = fx;
    it.fy = fy;
    it.sx = sx;
    it.sy = sy;
    it.radius = r;
    return it;
  endfunction

  function automatic shape_req_t advance_req();
    shape_req_t it;
    it = shape_start(1'($urandom_range(1)), CB'($urandom), CB'($urandom),
                     CB'($urandom), CB'($urandom), RB'($urandom));
    it.req = REQ_ADVANCE;
    return it;
  endfunction

  task automatic send_item(shape_req_t it);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.req_type <= it.req;
    in_ch.shape_kind <= it.kind;
    in_ch.first_x <= it.fx;
    in_ch.first_y <= it.fy;
    in_ch.second_x <= it.sx;
    in_ch.second_y <= it.sy;
    in_ch.radius_in <= it.radius;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sb.note_request(it);
    items_sent++;
  endtask

  task automatic send_advances(int n);
    repeat (n) send_item(advance_req());
  endtask

  task automatic run_random_phase(int goal);
    int roll;
    int r;
    while (items_sent < goal) begin
      roll = $urandom_range(99);
      if (roll < 8) begin
        send_item(advance_req());
      end else begin
        roll = $urandom_range(99);
        if (roll < 78) r = $urandom_range(5);
        else if (roll < 93) r = $urandom_range(12, 6);
        else r = $urandom_range(RMAX, 13);
        send_item(shape_start(1'($urandom_range(1)), CB'($urandom), CB'($urandom),
                              CB'($urandom), CB'($urandom), RB'(r)));
        // abandon large shapes and some small ones part way through
        if (r > 12 || $urandom_range(99) < 12) begin
          send_advances($urandom_range(40));
        end else begin
          while (sb.is_drawing()) send_item(advance_req());
        end
      end
    end
  endtask

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        sb.check_point({out_ch.point_x, out_ch.point_y, out_ch.point_valid, out_ch.last_point});
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
          (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    sb = new();
    sender_idle_pct = 0;
    recv_stall_pct = 0;
    items_sent = 0;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.req_type <= REQ_START;
    in_ch.shape_kind <= KIND_CIRCLE;
    in_ch.first_x <= '0;
    in_ch.first_y <= '0;
    in_ch.second_x <= '0;
    in_ch.second_y <= '0;
    in_ch.radius_in <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(advance_req());
    send_item(shape_start(KIND_CIRCLE, 16'h7fff, 16'h8000, 16'h1234, 16'hedcb, '0));
    send_advances(8);
    send_item(shape_start(KIND_RRECT, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000, RB'(RMAX)));
    send_advances(3);
    send_item(shape_start(KIND_RRECT, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff, '0));
    send_advances(8);
    send_item(advance_req());

    sender_idle_pct = 0;
    recv_stall_pct = 0;
    run_random_phase(items_sent + RANDOM_ITEMS / 4);
    sender_idle_pct = 66;
    recv_stall_pct = 0;
    run_random_phase(items_sent + RANDOM_ITEMS / 4);
    sender_idle_pct = 0;
    recv_stall_pct = 66;
    run_random_phase(items_sent + RANDOM_ITEMS / 4);
    sender_idle_pct = 29;
    recv_stall_pct = 29;
    run_random_phase(items_sent + RANDOM_ITEMS / 4);
    in_ch.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (sb.errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
